FILE: rtl/lscf_pkg.sv
// Shared types and constants for the lidar scan curvature feature block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lscf_pkg;

   localparam int POS_W      = 16;
   localparam int CURV_W     = 41;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CURV_W-1:0]     THRESH_RESET     = 41'd104858;
   localparam logic [CURV_W-1:0]     CURV_MAX         = {CURV_W{1'b1}};
   localparam logic [CSR_ADDR_W-1:0] ADDR_CURV_THRESH = 3'd0;

   typedef logic signed [POS_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   // advance: every pipeline stage moves one place; accept: an item enters
   typedef struct packed {
      logic advance;
      logic accept;
   } pipe_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/lscf_window.sv
// Point window of the curvature block: shift line of points and line-end
// marks, running per-axis window totals and fill count. Uses lscf_pkg.
`default_nettype none

module lscf_window #(
   parameter int HALF_WINDOW = 5,
   parameter int DIFF_W      = 22
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lscf_pkg::pipe_ctl_type    ctl,
   input  wire lscf_pkg::point_type       in_point,
   input  wire logic                      in_line_end,
   output logic                           fresh,
   output lscf_pkg::point_type            centre,
   output logic signed [DIFF_W-1:0]       diff_x,
   output logic signed [DIFF_W-1:0]       diff_y,
   output logic signed [DIFF_W-1:0]       diff_z,
   output logic                           window_ok
);
   import lscf_pkg::*;

   localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
   localparam int FILL_W  = $clog2(WIN_LEN + 1);
   localparam logic [FILL_W-1:0]        FILL_FULL = FILL_W'(WIN_LEN);
   localparam logic signed [DIFF_W-1:0] WIN_MUL   = DIFF_W'(WIN_LEN);

   point_type                  win_ff [WIN_LEN];
   logic [WIN_LEN-1:0]         le_ff;
   logic [FILL_W-1:0]          fill_ff;
   logic [FILL_W-1:0]          fill_in;
   logic signed [DIFF_W-1:0]   tot_x_ff, tot_y_ff, tot_z_ff;
   logic signed [DIFF_W-1:0]   tot_x_in, tot_y_in, tot_z_in;
   logic                       fresh_ff;

   // running totals: add the new point, drop the oldest
   always_comb begin
      tot_x_in = tot_x_ff + DIFF_W'(in_point.x) - DIFF_W'(win_ff[WIN_LEN-1].x);
      tot_y_in = tot_y_ff + DIFF_W'(in_point.y) - DIFF_W'(win_ff[WIN_LEN-1].y);
      tot_z_in = tot_z_ff + DIFF_W'(in_point.z) - DIFF_W'(win_ff[WIN_LEN-1].z);
      fill_in  = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WIN_LEN; k++) begin
            win_ff[k] <= '0;
         end
         le_ff    <= '0;
         fill_ff  <= '0;
         tot_x_ff <= '0;
         tot_y_ff <= '0;
         tot_z_ff <= '0;
         fresh_ff <= 1'b0;
      end else begin
         if (ctl.advance) begin
            fresh_ff <= ctl.accept;
         end
         if (ctl.accept) begin
            win_ff[0] <= in_point;
            for (int k = 1; k < WIN_LEN; k++) begin
               win_ff[k] <= win_ff[k-1];
            end
            le_ff    <= {le_ff[WIN_LEN-2:0], in_line_end};
            fill_ff  <= fill_in;
            tot_x_ff <= tot_x_in;
            tot_y_ff <= tot_y_in;
            tot_z_ff <= tot_z_in;
         end
      end
   end

   // neighbors minus 2H times center equals total minus (2H+1) times center
   always_comb begin
      centre    = win_ff[HALF_WINDOW];
      diff_x    = tot_x_ff - WIN_MUL * DIFF_W'(win_ff[HALF_WINDOW].x);
      diff_y    = tot_y_ff - WIN_MUL * DIFF_W'(win_ff[HALF_WINDOW].y);
      diff_z    = tot_z_ff - WIN_MUL * DIFF_W'(win_ff[HALF_WINDOW].z);
      // a mark on the newest point only closes the current line
      window_ok = (fill_ff == FILL_FULL) && !(|le_ff[WIN_LEN-1:1]);
      fresh     = fresh_ff;
   end

endmodule

`default_nettype wire

FILE: rtl/lscf_score.sv
// Curvature scoring pipeline: squares of the window differences, their
// saturated sum, and sharp or flat flags against the threshold. Uses lscf_pkg.
`default_nettype none

module lscf_score #(
   parameter int DIFF_W = 22
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lscf_pkg::pipe_ctl_type         ctl,
   input  wire logic                           fresh,
   input  wire lscf_pkg::point_type            centre,
   input  wire logic signed [DIFF_W-1:0]       diff_x,
   input  wire logic signed [DIFF_W-1:0]       diff_y,
   input  wire logic signed [DIFF_W-1:0]       diff_z,
   input  wire logic                           window_ok,
   input  wire logic [lscf_pkg::CURV_W-1:0]    threshold,
   output logic                                out_valid,
   output lscf_pkg::point_type                 out_centre,
   output logic [lscf_pkg::CURV_W-1:0]         out_curvature,
   output logic                                out_curve_valid,
   output logic                                out_sharp,
   output logic                                out_flat
);
   import lscf_pkg::*;

   localparam int ABS_W = DIFF_W - 1;
   localparam int SQ_W  = 2 * ABS_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int EXT_W = (SUM_W > CURV_W) ? SUM_W : CURV_W;

   function automatic logic [ABS_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
      logic signed [DIFF_W-1:0] n;
      n = (d < 0) ? -d : d;
      return n[ABS_W-1:0];
   endfunction

   // stage B: window differences
   logic                     b_vld_ff, b_ok_ff;
   point_type                b_pt_ff;
   logic signed [DIFF_W-1:0] b_dx_ff, b_dy_ff, b_dz_ff;
   // stage C: squares
   logic                     c_vld_ff, c_ok_ff;
   point_type                c_pt_ff;
   logic [SQ_W-1:0]          c_sx_ff, c_sy_ff, c_sz_ff;
   logic [SQ_W-1:0]          sx_in, sy_in, sz_in;
   logic [ABS_W-1:0]         ax, ay, az;
   // stage D: saturated curvature
   logic                     d_vld_ff, d_ok_ff;
   point_type                d_pt_ff;
   logic [CURV_W-1:0]        d_curv_ff, curv_in;
   logic [EXT_W-1:0]         sum_ext;
   // stage E: result register
   logic                     e_vld_ff, e_ok_ff, e_sharp_ff, e_flat_ff;
   point_type                e_pt_ff;
   logic [CURV_W-1:0]        e_curv_ff;

   always_comb begin
      ax      = mag(b_dx_ff);
      ay      = mag(b_dy_ff);
      az      = mag(b_dz_ff);
      sx_in   = SQ_W'(ax) * SQ_W'(ax);
      sy_in   = SQ_W'(ay) * SQ_W'(ay);
      sz_in   = SQ_W'(az) * SQ_W'(az);
      sum_ext = EXT_W'(SUM_W'(c_sx_ff) + SUM_W'(c_sy_ff) + SUM_W'(c_sz_ff));
      curv_in = (sum_ext > EXT_W'(CURV_MAX)) ? CURV_MAX : sum_ext[CURV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else if (ctl.advance) begin
         b_vld_ff <= fresh;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         b_ok_ff    <= window_ok;
         b_pt_ff    <= centre;
         b_dx_ff    <= diff_x;
         b_dy_ff    <= diff_y;
         b_dz_ff    <= diff_z;

         c_ok_ff    <= b_ok_ff;
         c_pt_ff    <= b_pt_ff;
         c_sx_ff    <= sx_in;
         c_sy_ff    <= sy_in;
         c_sz_ff    <= sz_in;

         d_ok_ff    <= c_ok_ff;
         d_pt_ff    <= c_pt_ff;
         d_curv_ff  <= curv_in;

         e_ok_ff    <= d_ok_ff;
         e_pt_ff    <= d_pt_ff;
         e_curv_ff  <= d_curv_ff;
         e_sharp_ff <= d_ok_ff && (d_curv_ff > threshold);
         e_flat_ff  <= d_ok_ff && (d_curv_ff < threshold);
      end
   end

   always_comb begin
      out_valid       = e_vld_ff;
      out_centre      = e_pt_ff;
      out_curvature   = e_curv_ff;
      out_curve_valid = e_ok_ff;
      out_sharp       = e_sharp_ff;
      out_flat        = e_flat_ff;
   end

endmodule

`default_nettype wire

FILE: rtl/lidar_scan_curvature_features.sv
// Lidar scan curvature features: one result per point, for the point
// HALF_WINDOW items back. The window shift line feeds a four-stage difference,
// square, sum and compare pipeline that takes one item per cycle while the
// result channel is not stalled.
// Synchronous reset clears the window, line marks, fill count and pipeline,
// and loads the curvature threshold with its default.
`default_nettype none

module lidar_scan_curvature_features #(
   parameter int HALF_WINDOW = 5
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic signed [lscf_pkg::POS_W-1:0] req_pos_x,
   input  wire logic signed [lscf_pkg::POS_W-1:0] req_pos_y,
   input  wire logic signed [lscf_pkg::POS_W-1:0] req_pos_z,
   input  wire logic                             req_line_end,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [lscf_pkg::POS_W-1:0]     rsp_centre_x,
   output logic signed [lscf_pkg::POS_W-1:0]     rsp_centre_y,
   output logic signed [lscf_pkg::POS_W-1:0]     rsp_centre_z,
   output logic [lscf_pkg::CURV_W-1:0]           rsp_curvature,
   output logic                                  rsp_curve_valid,
   output logic                                  rsp_sharp_candidate,
   output logic                                  rsp_flat_candidate,
   // configuration port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [lscf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [lscf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lscf_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import lscf_pkg::*;

   localparam int DIFF_W = $clog2(4 * HALF_WINDOW) + POS_W + 1;

   pipe_ctl_type             ctl;
   point_type                in_point;
   point_type                centre;
   point_type                out_centre;
   logic                     fresh;
   logic                     window_ok;
   logic signed [DIFF_W-1:0] diff_x, diff_y, diff_z;
   logic [CURV_W-1:0]        thresh_ff;
   logic                     csr_wr;

   // the whole pipeline holds only while a finished result is stalled
   always_comb begin
      ctl.advance = !rsp_valid || !rsp_stall;
      ctl.accept  = req_valid && ctl.advance;
      req_stall   = !ctl.advance;
      in_point.x  = req_pos_x;
      in_point.y  = req_pos_y;
      in_point.z  = req_pos_z;
   end

   // configuration register
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_wr && (csr_paddr == ADDR_CURV_THRESH)) begin
         thresh_ff <= csr_pwdata[CURV_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_CURV_THRESH) begin
         csr_prdata = CSR_DATA_W'(thresh_ff);
      end
   end

   lscf_window #(
      .HALF_WINDOW (HALF_WINDOW),
      .DIFF_W      (DIFF_W)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .in_point    (in_point),
      .in_line_end (req_line_end),
      .fresh       (fresh),
      .centre      (centre),
      .diff_x      (diff_x),
      .diff_y      (diff_y),
      .diff_z      (diff_z),
      .window_ok   (window_ok)
   );

   lscf_score #(
      .DIFF_W (DIFF_W)
   ) u_score (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .fresh           (fresh),
      .centre          (centre),
      .diff_x          (diff_x),
      .diff_y          (diff_y),
      .diff_z          (diff_z),
      .window_ok       (window_ok),
      .threshold       (thresh_ff),
      .out_valid       (rsp_valid),
      .out_centre      (out_centre),
      .out_curvature   (rsp_curvature),
      .out_curve_valid (rsp_curve_valid),
      .out_sharp       (rsp_sharp_candidate),
      .out_flat        (rsp_flat_candidate)
   );

   always_comb begin
      rsp_centre_x = out_centre.x;
      rsp_centre_y = out_centre.y;
      rsp_centre_z = out_centre.z;
   end

   // input backpressure comes only from a stalled result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // candidate flags only on valid windows
   a_flag_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_sharp_candidate || rsp_flat_candidate)) |-> rsp_curve_valid)
      else $error("candidate flag on an invalid window");

   // flags agree with the curvature and the threshold
   a_flag_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_curve_valid) |->
         ((rsp_sharp_candidate == (rsp_curvature > thresh_ff)) &&
          (rsp_flat_candidate == (rsp_curvature < thresh_ff))))
      else $error("candidate flags disagree with curvature");

endmodule

`default_nettype wire

FILE: sim/tb_lidar_scan_curvature_features.sv
// Testbench for lidar_scan_curvature_features: scan-line point streams in, curvature scores out.
// Depends on rtl/lscf_pkg.sv and rtl/lidar_scan_curvature_features.sv; self-checking.
module tb_lidar_scan_curvature_features;
   timeunit 1ns;
   timeprecision 1ps;

   import lscf_pkg::*;

   localparam int  HALF       = 5;
   localparam int  WIN        = 2 * HALF + 1;
   localparam real CLK_PERIOD = 12.0;
   localparam int  PHASES     = 6;
   localparam int  PHASE_PTS  = 75;
   localparam logic [CURV_W-1:0] THRESH_TOP = 41'd1288490188800;

   typedef struct {
      point_type pt;
      logic      line_end;
   } lidar_item_type;

   typedef struct {
      point_type         centre;
      logic [CURV_W-1:0] curv;
      logic              valid;
      logic              sharp;
      logic              flat;
   } score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   coord_type             req_pos_x    = '0;
   coord_type             req_pos_y    = '0;
   coord_type             req_pos_z    = '0;
   logic                  req_line_end = 1'b0;

   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   coord_type             rsp_centre_x;
   coord_type             rsp_centre_y;
   coord_type             rsp_centre_z;
   logic [CURV_W-1:0]     rsp_curvature;
   logic                  rsp_curve_valid;
   logic                  rsp_sharp_candidate;
   logic                  rsp_flat_candidate;

   logic                  csr_psel     = 1'b0;
   logic                  csr_penable  = 1'b0;
   logic                  csr_pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr    = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata   = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   lidar_item_type point_queue[$];
   score_type      pending_scores[$];
   int             send_gap_pct = 0;
   int             stall_pct    = 0;
   int             fail_count   = 0;

   // scoring model state, index 0 newest
   point_type         scan_win[WIN];
   logic              line_marks[WIN];
   int                win_fill     = 0;
   logic [CURV_W-1:0] thresh_model = THRESH_RESET;

   lidar_scan_curvature_features #(.HALF_WINDOW(HALF)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z),
      .req_line_end(req_line_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_centre_x(rsp_centre_x),
      .rsp_centre_y(rsp_centre_y),
      .rsp_centre_z(rsp_centre_z),
      .rsp_curvature(rsp_curvature),
      .rsp_curve_valid(rsp_curve_valid),
      .rsp_sharp_candidate(rsp_sharp_candidate),
      .rsp_flat_candidate(rsp_flat_candidate),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #(CLK_PERIOD / 2.0) clock = ~clock;
   end

   initial begin
      for (int k = 0; k < WIN; k++) begin
         scan_win[k]   = '0;
         line_marks[k] = 1'b0;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   function automatic longint unsigned sq_mag(input longint d);
      longint unsigned a;
      a = (d < 0) ? longint'(-d) : longint'(d);
      return a * a;
   endfunction

   // shift the window, score its center, queue the expected result
   task automatic score_point(input coord_type x, input coord_type y, input coord_type z,
                              input logic le);
      longint          dx, dy, dz;
      longint unsigned curv;
      logic            ok;
      score_type       s;
      for (int k = WIN - 1; k > 0; k--) begin
         scan_win[k]   = scan_win[k-1];
         line_marks[k] = line_marks[k-1];
      end
      scan_win[0]   = '{x: x, y: y, z: z};
      line_marks[0] = le;
      if (win_fill < WIN) win_fill++;
      dx = 0;
      dy = 0;
      dz = 0;
      for (int k = 0; k < WIN; k++) begin
         if (k != HALF) begin
            dx += longint'($signed(scan_win[k].x));
            dy += longint'($signed(scan_win[k].y));
            dz += longint'($signed(scan_win[k].z));
         end
      end
      dx -= 2 * HALF * longint'($signed(scan_win[HALF].x));
      dy -= 2 * HALF * longint'($signed(scan_win[HALF].y));
      dz -= 2 * HALF * longint'($signed(scan_win[HALF].z));
      curv = sq_mag(dx) + sq_mag(dy) + sq_mag(dz);
      if (curv > CURV_MAX) curv = CURV_MAX;
      // a mark on the newest point only closes the current line
      ok = (win_fill == WIN);
      for (int k = 1; k < WIN; k++)
         if (line_marks[k]) ok = 1'b0;
      s.centre = scan_win[HALF];
      s.curv   = curv[CURV_W-1:0];
      s.valid  = ok;
      s.sharp  = ok && (curv > thresh_model);
      s.flat   = ok && (curv < thresh_model);
      pending_scores = {pending_scores, s};
   endtask

   // driver: offer the next point once the current one is taken
   always @(posedge clock) begin
      lidar_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            score_point(req_pos_x, req_pos_y, req_pos_z, req_line_end);
         if (!req_valid || !req_stall) begin
            if (point_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               it = point_queue.pop_front();
               req_valid    <= 1'b1;
               req_pos_x    <= it.pt.x;
               req_pos_y    <= it.pt.y;
               req_pos_z    <= it.pt.z;
               req_line_end <= it.line_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare every taken result with the oldest expected score
   always @(posedge clock) begin
      score_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_scores.size() == 0) begin
               report_mismatch("result with no pending point");
            end else begin
               want = pending_scores.pop_front();
               cmp_field("centre_x", rsp_centre_x, want.centre.x);
               cmp_field("centre_y", rsp_centre_y, want.centre.y);
               cmp_field("centre_z", rsp_centre_z, want.centre.z);
               cmp_field("curvature", rsp_curvature, want.curv);
               cmp_field("curve_valid", rsp_curve_valid, want.valid);
               cmp_field("sharp_candidate", rsp_sharp_candidate, want.sharp);
               cmp_field("flat_candidate", rsp_flat_candidate, want.flat);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic push_point(input int x, input int y, input int z, input logic le);
      lidar_item_type it;
      it.pt.x     = x[15:0];
      it.pt.y     = y[15:0];
      it.pt.z     = z[15:0];
      it.line_end = le;
      point_queue = {point_queue, it};
   endtask

   // mostly whole scan lines with smooth or noisy content, some short or broken ones
   task automatic push_scan_lines(input int count);
      int n, len, amp, pick;
      int bx, by, bz, sx, sy, sz, x, y, z;
      logic le;
      n = 0;
      while (n < count) begin
         len  = ($urandom_range(99) < 80) ? $urandom_range(11, 40) : $urandom_range(1, 10);
         pick = $urandom_range(3);
         amp  = (pick == 0) ? 0 : (pick == 1) ? 7 : (pick == 2) ? 300 : -1;
         bx   = int'($urandom_range(65535)) - 32768;
         by   = int'($urandom_range(65535)) - 32768;
         bz   = int'($urandom_range(65535)) - 32768;
         sx   = int'($urandom_range(128)) - 64;
         sy   = int'($urandom_range(128)) - 64;
         sz   = int'($urandom_range(128)) - 64;
         for (int k = 0; k < len; k++) begin
            if (amp < 0) begin
               x = $urandom;
               y = $urandom;
               z = $urandom;
            end else begin
               x = bx + sx * k + int'($urandom_range(2 * amp)) - amp;
               y = by + sy * k + int'($urandom_range(2 * amp)) - amp;
               z = bz + sz * k + int'($urandom_range(2 * amp)) - amp;
            end
            if ($urandom_range(99) < 4) x = $urandom;
            le = (k == len - 1);
            if ($urandom_range(99) < 3) le = ~le;
            push_point(x, y, z, le);
         end
         n += len;
      end
   endtask

   task automatic read_threshold();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_CURV_THRESH;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cmp_field("csr readback", csr_prdata, {{(CSR_DATA_W-CURV_W){1'b0}}, thresh_model});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_threshold(input logic [CURV_W-1:0] v);
      logic [CSR_DATA_W-CURV_W-1:0] junk;
      junk = (CSR_DATA_W-CURV_W)'($urandom);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_CURV_THRESH;
      csr_pwdata  <= {junk, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      thresh_model = v;
      read_threshold();
   endtask

   // wait until every point is taken and every score has come back
   task automatic drain();
      while (point_queue.size() != 0 || req_valid || pending_scores.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [CURV_W-1:0] th;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      read_threshold();

      // one neighbor at (323, 23, 0) scores exactly the default threshold
      for (int k = 0; k < 11; k++) begin
         if (k == 4) push_point(323, 23, 0, 1'b0);
         else        push_point(0, 0, 0, k == 10);
      end
      push_point(32767, 32767, 32767, 1'b0);
      push_point(-32768, -32768, -32768, 1'b0);
      push_point(32767, -32768, 32767, 1'b0);
      push_point(-32768, 32767, -32768, 1'b1);
      push_point(-32768, 32767, 32767, 1'b0);
      for (int k = 0; k < 5; k++) push_point(32767, 32767, 32767, 1'b0);
      push_point(-32768, -32768, -32768, 1'b0);
      push_point(32767, 32767, 32767, 1'b1);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0) begin
            drain();
            case (ph)
               1:       th = '0;
               2:       th = THRESH_TOP;
               3:       th = CURV_W'($urandom_range(0, 1 << 21));
               4:       th = THRESH_RESET;
               default: th = CURV_W'({$urandom, $urandom} % (THRESH_TOP + 1));
            endcase
            write_threshold(th);
         end
         @(posedge clock);
         case (ph % 4)
            0: begin send_gap_pct <= 0;  stall_pct <= 0;  end
            1: begin send_gap_pct <= 65; stall_pct <= 0;  end
            2: begin send_gap_pct <= 0;  stall_pct <= 65; end
            default: begin send_gap_pct <= 36; stall_pct <= 36; end
         endcase
         push_scan_lines(PHASE_PTS);
      end
      drain();

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(CLK_PERIOD * 400000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
rtl/lscf_pkg.sv
rtl/lscf_window.sv
rtl/lscf_score.sv
rtl/lidar_scan_curvature_features.sv
sim/tb_lidar_scan_curvature_features.sv
